>>> rtl/jsu_pkg.sv
// jsu_pkg: shared types, character codes and the hex digit decoder
// for the json string unescaper.
// No dependencies.
package jsu_pkg;

    localparam logic [7:0] CHAR_QUOTE     = 8'h22;
    localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
    localparam logic [7:0] CHAR_B         = 8'h62;
    localparam logic [7:0] CHAR_F         = 8'h66;
    localparam logic [7:0] CHAR_R         = 8'h72;
    localparam logic [7:0] CHAR_N         = 8'h6E;
    localparam logic [7:0] CHAR_T         = 8'h74;
    localparam logic [7:0] CHAR_U         = 8'h75;

    localparam logic [7:0] CTRL_BS = 8'h08;
    localparam logic [7:0] CTRL_FF = 8'h0C;
    localparam logic [7:0] CTRL_CR = 8'h0D;
    localparam logic [7:0] CTRL_LF = 8'h0A;
    localparam logic [7:0] CTRL_HT = 8'h09;

    // depth of the result buffer, also the most results one input beat can cause
    localparam int unsigned RES_DEPTH = 2;

    typedef struct packed {
        logic [7:0] data;
        logic       has_byte;
        logic       last;
        logic       bad_framing;
    } result_t;

    // results of one decoded beat, in emission order
    typedef struct packed {
        logic [1:0] count;
        result_t    res0;
        result_t    res1;
    } decode_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } hex_t;

    function automatic hex_t hex_value(input logic [7:0] c);
        hex_t h;
        h.ok    = 1'b1;
        h.value = 4'd0;
        if (c inside {[8'h30:8'h39]})
        begin
            h.value = 4'(c - 8'h30);
        end
        else if (c inside {[8'h61:8'h66]})
        begin
            h.value = 4'(c - 8'h61 + 8'd10);
        end
        else if (c inside {[8'h41:8'h46]})
        begin
            h.value = 4'(c - 8'h41 + 8'd10);
        end
        else
        begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

    function automatic result_t data_result(input logic [7:0] b);
        result_t r;
        r.data        = b;
        r.has_byte    = 1'b1;
        r.last        = 1'b0;
        r.bad_framing = 1'b0;
        return r;
    endfunction

    function automatic result_t end_result(input logic bad);
        result_t r;
        r.data        = 8'h00;
        r.has_byte    = 1'b0;
        r.last        = 1'b1;
        r.bad_framing = bad;
        return r;
    endfunction

endpackage

>>> rtl/json_string_unescaper.sv
// json_string_unescaper: top level, input beat register feeding the parser
// and the two-entry result buffer.
// Depends on jsu_pkg, jsu_parser, jsu_result_buf.
//
//   channel   signals                                          direction
//   input     in_valid in_ready in_byte in_last                in
//   output    out_valid out_ready out_byte has_byte            out
//             out_last bad_framing
//
// one input beat per cycle while each beat gives at most one result and
// the output keeps taking results; the first result goes through the
// input beat register and then the result buffer before it is presented.
// a beat giving two results waits until the result buffer is empty, and
// a later beat that gives a result waits while both results are held.
// reset clears the parse state and empties both the input register and the
// result buffer. output stalls back up through the two-entry buffer.
module json_string_unescaper
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       has_byte,
    output logic       out_last,
    output logic       bad_framing
);

    logic             beat_valid_reg;
    logic [7:0]       beat_byte_reg;
    logic             beat_last_reg;
    logic             room;
    logic             fire;
    jsu_pkg::decode_t dec;
    jsu_pkg::result_t head;

    assign fire     = beat_valid_reg && room;
    assign in_ready = !beat_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beat_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            beat_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            beat_byte_reg <= in_byte;
            beat_last_reg <= in_last;
        end
    end

    jsu_parser u_parser
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (fire),
        .in_byte (beat_byte_reg),
        .in_last (beat_last_reg),
        .dec     (dec)
    );

    jsu_result_buf u_result_buf
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (fire),
        .dec   (dec),
        .room  (room),
        .valid (out_valid),
        .ready (out_ready),
        .head  (head)
    );

    assign out_byte    = head.data;
    assign has_byte    = head.has_byte;
    assign out_last    = head.last;
    assign bad_framing = head.bad_framing;

endmodule

>>> rtl/jsu_parser.sv
// jsu_parser: parse state and the per-beat decode of one string byte
// into zero, one or two results.
// Depends on jsu_pkg.
module jsu_parser
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic [7:0]           in_byte,
    input  logic                 in_last,
    output jsu_pkg::decode_t     dec
);

    typedef enum logic [2:0]
    {
        MODE_WAIT    = 3'd0,
        MODE_BODY    = 3'd1,
        MODE_ESCAPE  = 3'd2,
        MODE_HEX     = 3'd3,
        MODE_DISCARD = 3'd4
    } mode_t;

    mode_t      mode_reg, mode_next;
    logic [1:0] pos_reg, pos_next;
    logic [7:0] held_reg, held_next;

    jsu_pkg::hex_t hex_in;
    jsu_pkg::hex_t hex_held;
    logic [7:0]    pair_value;
    logic          in_string;

    assign hex_in     = jsu_pkg::hex_value(in_byte);
    assign hex_held   = jsu_pkg::hex_value(held_reg);
    assign pair_value = {hex_held.value, hex_in.value};
    assign in_string  = mode_reg inside {MODE_BODY, MODE_ESCAPE, MODE_HEX};

    always_comb
    begin
        mode_next  = mode_reg;
        pos_next   = pos_reg;
        held_next  = held_reg;
        dec.count  = 2'd0;
        dec.res0   = jsu_pkg::data_result(in_byte);
        dec.res1   = jsu_pkg::end_result(1'b0);

        if (in_last)
        begin
            if (in_string && in_byte == jsu_pkg::CHAR_QUOTE)
            begin
                // half-read digit pair goes out ahead of the end marker
                if (mode_reg == MODE_HEX && pos_reg[0])
                begin
                    dec.count = 2'd2;
                    dec.res0  = jsu_pkg::data_result(held_reg);
                    dec.res1  = jsu_pkg::end_result(1'b0);
                end
                else
                begin
                    dec.count = 2'd1;
                    dec.res0  = jsu_pkg::end_result(1'b0);
                end
            end
            else
            begin
                dec.count = 2'd1;
                dec.res0  = jsu_pkg::end_result(1'b1);
            end
            mode_next = MODE_WAIT;
            pos_next  = 2'd0;
            held_next = 8'h00;
        end
        else
        begin
            case (mode_reg)
                MODE_WAIT:
                begin
                    mode_next = (in_byte == jsu_pkg::CHAR_QUOTE) ? MODE_BODY : MODE_DISCARD;
                end
                MODE_DISCARD:
                begin
                    mode_next = MODE_DISCARD;
                end
                MODE_BODY:
                begin
                    if (in_byte == jsu_pkg::CHAR_BACKSLASH)
                    begin
                        mode_next = MODE_ESCAPE;
                    end
                    else
                    begin
                        dec.count = 2'd1;
                    end
                end
                MODE_ESCAPE:
                begin
                    mode_next = MODE_BODY;
                    dec.count = 2'd1;
                    case (in_byte)
                        jsu_pkg::CHAR_B: dec.res0 = jsu_pkg::data_result(jsu_pkg::CTRL_BS);
                        jsu_pkg::CHAR_F: dec.res0 = jsu_pkg::data_result(jsu_pkg::CTRL_FF);
                        jsu_pkg::CHAR_R: dec.res0 = jsu_pkg::data_result(jsu_pkg::CTRL_CR);
                        jsu_pkg::CHAR_N: dec.res0 = jsu_pkg::data_result(jsu_pkg::CTRL_LF);
                        jsu_pkg::CHAR_T: dec.res0 = jsu_pkg::data_result(jsu_pkg::CTRL_HT);
                        jsu_pkg::CHAR_U:
                        begin
                            mode_next = MODE_HEX;
                            pos_next  = 2'd0;
                            held_next = 8'h00;
                            dec.count = 2'd0;
                        end
                        default:
                        begin
                            dec.res0 = jsu_pkg::data_result(in_byte);
                        end
                    endcase
                end
                MODE_HEX:
                begin
                    if (hex_in.ok)
                    begin
                        if (!pos_reg[0])
                        begin
                            held_next = in_byte;
                            pos_next  = pos_reg + 2'd1;
                        end
                        else
                        begin
                            held_next = 8'h00;
                            dec.res0  = jsu_pkg::data_result(pair_value);
                            if (pos_reg == 2'd1)
                            begin
                                // high byte of zero is skipped
                                pos_next  = 2'd2;
                                dec.count = (pair_value != 8'h00) ? 2'd1 : 2'd0;
                            end
                            else
                            begin
                                mode_next = MODE_BODY;
                                pos_next  = 2'd0;
                                dec.count = 2'd1;
                            end
                        end
                    end
                    else
                    begin
                        // escape aborted: flush a held digit, then treat as a body byte
                        mode_next = MODE_BODY;
                        pos_next  = 2'd0;
                        held_next = 8'h00;
                        if (in_byte == jsu_pkg::CHAR_BACKSLASH)
                        begin
                            mode_next = MODE_ESCAPE;
                            if (pos_reg[0])
                            begin
                                dec.count = 2'd1;
                                dec.res0  = jsu_pkg::data_result(held_reg);
                            end
                        end
                        else if (pos_reg[0])
                        begin
                            dec.count = 2'd2;
                            dec.res0  = jsu_pkg::data_result(held_reg);
                            dec.res1  = jsu_pkg::data_result(in_byte);
                        end
                        else
                        begin
                            dec.count = 2'd1;
                            dec.res0  = jsu_pkg::data_result(in_byte);
                        end
                    end
                end
                default:
                begin
                    mode_next = MODE_WAIT;
                    pos_next  = 2'd0;
                    held_next = 8'h00;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_WAIT;
            pos_reg  <= 2'd0;
            held_reg <= 8'h00;
        end
        else if (step)
        begin
            mode_reg <= mode_next;
            pos_reg  <= pos_next;
            held_reg <= held_next;
        end
    end

endmodule

>>> rtl/jsu_result_buf.sv
// jsu_result_buf: two-entry result register that takes up to two results
// per beat and presents them one at a time on the output channel.
// Depends on jsu_pkg.
module jsu_result_buf
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  jsu_pkg::decode_t     dec,
    output logic                 room,
    output logic                 valid,
    input  logic                 ready,
    output jsu_pkg::result_t     head
);

    jsu_pkg::result_t slot0_reg, slot0_next;
    jsu_pkg::result_t slot1_reg, slot1_next;
    logic [1:0]       count_reg, count_next;
    logic [1:0]       kept;
    logic [1:0]       push_count;
    logic             pop;

    assign valid = (count_reg != 2'd0);
    assign head  = slot0_reg;
    assign pop   = valid && ready;

    // room is judged on the current fill only, so ready never reaches the input side
    assign room = (3'(count_reg) + 3'(dec.count)) <= 3'(jsu_pkg::RES_DEPTH);

    assign push_count = push ? dec.count : 2'd0;

    always_comb
    begin
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        kept       = count_reg;
        if (pop)
        begin
            slot0_next = slot1_reg;
            kept       = count_reg - 2'd1;
        end
        if (push_count != 2'd0)
        begin
            if (kept == 2'd0)
            begin
                slot0_next = dec.res0;
                slot1_next = dec.res1;
            end
            else
            begin
                slot1_next = dec.res0;
            end
        end
        count_next = kept + push_count;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule

>>> tb/tb_json_string_unescaper.sv
// tb_json_string_unescaper: self-checking bench for the json string unescaper,
// a directed table of beats followed by random quoted strings and noise.
// Depends on jsu_pkg and json_string_unescaper.
`timescale 1ns / 100ps

module tb_json_string_unescaper;

    import jsu_pkg::*;

    typedef enum logic [2:0]
    {
        PM_WAIT,
        PM_BODY,
        PM_ESC,
        PM_HEX,
        PM_DISCARD
    } parse_mode_t;

    // one input beat; exp_n < 0 means the expected results come from the predictor
    typedef struct
    {
        logic [7:0] b;
        logic       lst;
        int         exp_n;
        result_t    exp0;
        result_t    exp1;
    } beat_t;

    localparam result_t NO_RESULT = '0;
    localparam int DIRECTED_ROWS = 27;
    localparam int RANDOM_BEATS  = 500;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] in_byte = 8'h00;
    logic       in_last = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] out_byte;
    logic       has_byte;
    logic       out_last;
    logic       bad_framing;

    json_string_unescaper dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_byte     (in_byte),
        .in_last     (in_last),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .has_byte    (has_byte),
        .out_last    (out_last),
        .bad_framing (bad_framing)
    );

    always #4 clk = ~clk;

    // predictor state
    parse_mode_t pmode = PM_WAIT;
    logic [1:0]  digit_pos = 2'd0;
    logic [7:0]  held_char = 8'h00;
    result_t     step_res [2];

    beat_t   beat_queue [$];
    result_t pending_results [$];
    beat_t   directed_rows [DIRECTED_ROWS];
    beat_t   cur_beat;
    result_t seen_want;
    int      errors = 0;
    int      beats_in = 0;
    int      n_res;
    logic    quiet;

    // both sides stop idling for a while in the middle of the run
    assign quiet = (beats_in >= 250) && (beats_in < 400);

    function automatic result_t as_data(input logic [7:0] b);
        return {b, 1'b1, 1'b0, 1'b0};
    endfunction

    function automatic result_t as_end(input logic bad);
        return {8'h00, 1'b0, 1'b1, bad};
    endfunction

    // {is hex, nibble value}
    function automatic logic [4:0] hex_nib(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39)
        begin
            return {1'b1, 4'(c - 8'h30)};
        end
        if (c >= 8'h61 && c <= 8'h66)
        begin
            return {1'b1, 4'(c - 8'h57)};
        end
        if (c >= 8'h41 && c <= 8'h46)
        begin
            return {1'b1, 4'(c - 8'h37)};
        end
        return 5'd0;
    endfunction

    // advances the parse state by one beat, fills step_res, returns the result count
    function automatic int unesc_step(input logic [7:0] b, input logic lst);
        int         n;
        logic       in_str;
        logic [7:0] pair;
        logic [4:0] nib_b;
        logic [4:0] nib_h;
        n = 0;
        if (lst)
        begin
            in_str = (pmode == PM_BODY) || (pmode == PM_ESC) || (pmode == PM_HEX);
            if (in_str && b == CHAR_QUOTE)
            begin
                if (pmode == PM_HEX && digit_pos[0])
                begin
                    step_res[n] = as_data(held_char);
                    n++;
                end
                step_res[n] = as_end(1'b0);
                n++;
            end
            else
            begin
                step_res[n] = as_end(1'b1);
                n++;
            end
            pmode = PM_WAIT;
            digit_pos = 2'd0;
            held_char = 8'h00;
            return n;
        end
        case (pmode)
            PM_WAIT:
            begin
                pmode = (b == CHAR_QUOTE) ? PM_BODY : PM_DISCARD;
            end
            PM_DISCARD:
            begin
            end
            PM_BODY:
            begin
                if (b == CHAR_BACKSLASH)
                begin
                    pmode = PM_ESC;
                end
                else
                begin
                    step_res[0] = as_data(b);
                    n = 1;
                end
            end
            PM_ESC:
            begin
                pmode = PM_BODY;
                n = 1;
                case (b)
                    CHAR_B: step_res[0] = as_data(CTRL_BS);
                    CHAR_F: step_res[0] = as_data(CTRL_FF);
                    CHAR_R: step_res[0] = as_data(CTRL_CR);
                    CHAR_N: step_res[0] = as_data(CTRL_LF);
                    CHAR_T: step_res[0] = as_data(CTRL_HT);
                    CHAR_U:
                    begin
                        pmode = PM_HEX;
                        digit_pos = 2'd0;
                        held_char = 8'h00;
                        n = 0;
                    end
                    default: step_res[0] = as_data(b);
                endcase
            end
            PM_HEX:
            begin
                nib_b = hex_nib(b);
                nib_h = hex_nib(held_char);
                if (nib_b[4])
                begin
                    if (!digit_pos[0])
                    begin
                        held_char = b;
                        digit_pos = digit_pos + 2'd1;
                    end
                    else
                    begin
                        pair = {nib_h[3:0], nib_b[3:0]};
                        held_char = 8'h00;
                        if (digit_pos == 2'd1)
                        begin
                            // high byte of zero is dropped
                            digit_pos = 2'd2;
                            if (pair != 8'h00)
                            begin
                                step_res[0] = as_data(pair);
                                n = 1;
                            end
                        end
                        else
                        begin
                            pmode = PM_BODY;
                            digit_pos = 2'd0;
                            step_res[0] = as_data(pair);
                            n = 1;
                        end
                    end
                end
                else
                begin
                    // half-read pair goes out literally, then the byte is a body byte
                    if (digit_pos[0])
                    begin
                        step_res[n] = as_data(held_char);
                        n++;
                    end
                    pmode = PM_BODY;
                    digit_pos = 2'd0;
                    held_char = 8'h00;
                    if (b == CHAR_BACKSLASH)
                    begin
                        pmode = PM_ESC;
                    end
                    else
                    begin
                        step_res[n] = as_data(b);
                        n++;
                    end
                end
            end
            default:
            begin
                pmode = PM_WAIT;
                digit_pos = 2'd0;
                held_char = 8'h00;
            end
        endcase
        return n;
    endfunction

    task automatic add_beat(input logic [7:0] b, input logic lst);
        beat_t t;
        t.b = b;
        t.lst = lst;
        t.exp_n = -1;
        t.exp0 = NO_RESULT;
        t.exp1 = NO_RESULT;
        beat_queue.push_back(t);
    endtask

    function automatic logic [7:0] rand_hex();
        int v;
        v = $urandom_range(0, 21);
        if (v < 10)
        begin
            return 8'(8'h30 + v);
        end
        if (v < 16)
        begin
            return 8'(8'h61 + v - 10);
        end
        return 8'(8'h41 + v - 16);
    endfunction

    task automatic add_digits(input int k);
        int j;
        for (j = 0; j < k; j++)
        begin
            add_beat(rand_hex(), 1'b0);
        end
    endtask

    // one quoted string, mostly well formed, sometimes broken or plain noise
    task automatic gen_string();
        int         kind;
        int         pieces;
        int         p;
        int         r;
        logic [7:0] c;
        logic [4:0] nib;
        kind = $urandom_range(0, 99);
        if (kind < 10)
        begin
            pieces = $urandom_range(0, 6);
            add_beat(8'($urandom_range(0, 255)), pieces == 0);
            for (p = 0; p < pieces; p++)
            begin
                add_beat(8'($urandom_range(0, 255)), p == pieces - 1);
            end
            return;
        end
        add_beat(CHAR_QUOTE, 1'b0);
        pieces = $urandom_range(0, 8);
        for (p = 0; p < pieces; p++)
        begin
            r = $urandom_range(0, 99);
            if (r < 45)
            begin
                c = 8'($urandom_range(0, 255));
                if (c == CHAR_BACKSLASH)
                begin
                    c = 8'h41;
                end
                add_beat(c, 1'b0);
            end
            else if (r < 65)
            begin
                add_beat(CHAR_BACKSLASH, 1'b0);
                case ($urandom_range(0, 9))
                    0: c = CHAR_B;
                    1: c = CHAR_F;
                    2: c = CHAR_R;
                    3: c = CHAR_N;
                    4: c = CHAR_T;
                    5: c = CHAR_BACKSLASH;
                    6: c = CHAR_QUOTE;
                    7: c = 8'h2F;
                    default: c = 8'($urandom_range(0, 255));
                endcase
                add_beat(c, 1'b0);
            end
            else if (r < 85)
            begin
                add_beat(CHAR_BACKSLASH, 1'b0);
                add_beat(CHAR_U, 1'b0);
                if ($urandom_range(0, 99) < 30)
                begin
                    add_beat(8'h30, 1'b0);
                    add_beat(8'h30, 1'b0);
                end
                else
                begin
                    add_digits(2);
                end
                add_digits(2);
            end
            else
            begin
                // escape cut short by a non-hex byte
                add_beat(CHAR_BACKSLASH, 1'b0);
                add_beat(CHAR_U, 1'b0);
                add_digits($urandom_range(0, 3));
                c = 8'($urandom_range(0, 255));
                nib = hex_nib(c);
                while (nib[4])
                begin
                    c = 8'($urandom_range(0, 255));
                    nib = hex_nib(c);
                end
                add_beat(c, 1'b0);
            end
        end
        // sometimes leave an escape open right before the close
        r = $urandom_range(0, 99);
        if (r < 8)
        begin
            add_beat(CHAR_BACKSLASH, 1'b0);
        end
        else if (r < 16)
        begin
            add_beat(CHAR_BACKSLASH, 1'b0);
            add_beat(CHAR_U, 1'b0);
            add_digits($urandom_range(0, 3));
        end
        if (kind < 20)
        begin
            add_beat(8'($urandom_range(0, 255)), 1'b1);
        end
        else
        begin
            add_beat(CHAR_QUOTE, 1'b1);
        end
    endtask

    // input side: predict on each accepted beat, then present the next one
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                n_res = unesc_step(in_byte, in_last);
                if (cur_beat.exp_n >= 0)
                begin
                    if (cur_beat.exp_n > 0)
                    begin
                        pending_results.push_back(cur_beat.exp0);
                    end
                    if (cur_beat.exp_n > 1)
                    begin
                        pending_results.push_back(cur_beat.exp1);
                    end
                end
                else
                begin
                    for (int i = 0; i < n_res; i++)
                    begin
                        pending_results.push_back(step_res[i]);
                    end
                end
                beats_in++;
            end
            if (!in_valid || in_ready)
            begin
                if (beat_queue.size() != 0 && (quiet || $urandom_range(0, 99) >= 9))
                begin
                    cur_beat = beat_queue.pop_front();
                    in_valid <= 1'b1;
                    in_byte <= cur_beat.b;
                    in_last <= cur_beat.lst;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // output side: check each accepted beat against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("unexpected result beat: out_byte %02h has_byte %0b out_last %0b",
                           out_byte, has_byte, out_last);
                    errors++;
                end
                else
                begin
                    seen_want = pending_results.pop_front();
                    if (out_byte !== seen_want.data)
                    begin
                        $error("out_byte: expected %02h, got %02h", seen_want.data, out_byte);
                        errors++;
                    end
                    if (has_byte !== seen_want.has_byte)
                    begin
                        $error("has_byte: expected %0b, got %0b", seen_want.has_byte, has_byte);
                        errors++;
                    end
                    if (out_last !== seen_want.last)
                    begin
                        $error("out_last: expected %0b, got %0b", seen_want.last, out_last);
                        errors++;
                    end
                    if (bad_framing !== seen_want.bad_framing)
                    begin
                        $error("bad_framing: expected %0b, got %0b",
                               seen_want.bad_framing, bad_framing);
                        errors++;
                    end
                end
            end
            out_ready <= quiet || ($urandom_range(0, 99) >= 9);
        end
    end

    initial
    begin
        directed_rows = '{
            '{8'h78, 1'b0, -1, NO_RESULT, NO_RESULT},            // no opening quote
            '{8'hFF, 1'b1, 1, as_end(1'b1), NO_RESULT},
            '{CHAR_QUOTE, 1'b1, 1, as_end(1'b1), NO_RESULT},     // lone quote as last
            '{CHAR_QUOTE, 1'b0, -1, NO_RESULT, NO_RESULT},
            '{8'h00, 1'b0, 1, as_data(8'h00), NO_RESULT},
            '{8'hFF, 1'b0, 1, as_data(8'hFF), NO_RESULT},
            '{CHAR_QUOTE, 1'b0, 1, as_data(CHAR_QUOTE), NO_RESULT},  // inner quote is data
            '{CHAR_BACKSLASH, 1'b0, -1, NO_RESULT, NO_RESULT},
            '{CHAR_BACKSLASH, 1'b0, 1, as_data(CHAR_BACKSLASH), NO_RESULT},
            '{CHAR_BACKSLASH, 1'b0, -1, NO_RESULT, NO_RESULT},
            '{CHAR_N, 1'b0, 1, as_data(CTRL_LF), NO_RESULT},
            '{CHAR_BACKSLASH, 1'b0, -1, NO_RESULT, NO_RESULT},
            '{CHAR_U, 1'b0, -1, NO_RESULT, NO_RESULT},
            '{8'h30, 1'b0, -1, NO_RESULT, NO_RESULT},
            '{8'h30, 1'b0, -1, NO_RESULT, NO_RESULT},
            '{8'h30, 1'b0, -1, NO_RESULT, NO_RESULT},
            '{8'h30, 1'b0, 1, as_data(8'h00), NO_RESULT},        // zero low byte
            '{CHAR_BACKSLASH, 1'b0, -1, NO_RESULT, NO_RESULT},
            '{CHAR_U, 1'b0, -1, NO_RESULT, NO_RESULT},
            '{8'h41, 1'b0, -1, NO_RESULT, NO_RESULT},
            '{8'h67, 1'b0, -1, NO_RESULT, NO_RESULT},            // non-hex mid pair
            '{CHAR_BACKSLASH, 1'b0, -1, NO_RESULT, NO_RESULT},
            '{CHAR_U, 1'b0, -1, NO_RESULT, NO_RESULT},
            '{8'h37, 1'b0, -1, NO_RESULT, NO_RESULT},
            '{CHAR_QUOTE, 1'b1, -1, NO_RESULT, NO_RESULT},       // close with half pair
            '{CHAR_QUOTE, 1'b0, -1, NO_RESULT, NO_RESULT},
            '{8'h61, 1'b1, 1, as_end(1'b1), NO_RESULT}           // missing closing quote
        };
        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            beat_queue.push_back(directed_rows[i]);
        end
        while (beat_queue.size() < DIRECTED_ROWS + RANDOM_BEATS)
        begin
            gen_string();
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (beat_queue.size() != 0 || in_valid)
        begin
            @(posedge clk);
        end
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (16) @(posedge clk);

        if (errors == 0 && pending_results.size() == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

    initial
    begin
        #200000;
        $display("tb: failure");
        $finish;
    end

endmodule
